// File: design/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// shared types and constants of the grid depth-first path finder
// ----------------------------------------------------------------------------
package gdfs_pkg;

	localparam int GRID_SIDE = 4;
	localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
	localparam int COORD_W   = 2;
	localparam int CELL_W    = 2 * COORD_W;
	localparam int DEPTH_W   = 5;
	localparam int DIR_W     = 3;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 8;
	localparam int USER_W    = 2;

	// neighbor order, last code means all tried
	localparam logic [DIR_W-1:0] DIR_YDEC = 3'd0;
	localparam logic [DIR_W-1:0] DIR_XINC = 3'd1;
	localparam logic [DIR_W-1:0] DIR_XDEC = 3'd2;
	localparam logic [DIR_W-1:0] DIR_YINC = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DONE = 3'd4;

	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIDE - 1);
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NUM_CELLS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EXPLORE,
		ST_POP,
		ST_POP_WAIT,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [DIR_W-1:0]  next_dir;
		logic [CELL_W-1:0] pos;
		logic [CELL_W-1:0] parent;
	} stack_entry_t;

	localparam int ENTRY_W = $bits(stack_entry_t);

	typedef struct packed {
		logic [COORD_W-1:0] step_x;
		logic [COORD_W-1:0] step_y;
		logic               has_step;
		logic               found;
		logic               last;
	} result_t;

endpackage

// File: design/gdfs_ram.sv
// ----------------------------------------------------------------------------
// gdfs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/gdfs_search.sv
// ----------------------------------------------------------------------------
// gdfs_search
// backtracking search sequencer over the path stack ram, then path readout
// ----------------------------------------------------------------------------
module gdfs_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [gdfs_pkg::CELL_W-1:0]  start_cell,
	input  logic [gdfs_pkg::CELL_W-1:0]  target_cell,
	input  logic [gdfs_pkg::NUM_CELLS-1:0] safe_map,
	output logic                         res_valid,
	input  logic                         res_ready,
	output gdfs_pkg::result_t            res
);
	import gdfs_pkg::*;

	state_t                state_q, state_d;
	logic [DEPTH_W-1:0]    depth_q, depth_d;
	logic [NUM_CELLS-1:0]  onpath_q, onpath_d;
	logic [CELL_W-1:0]     cur_q, cur_d;
	logic [DIR_W-1:0]      dir_q, dir_d;
	logic [CELL_W-1:0]     target_q, target_d;
	logic [NUM_CELLS-1:0]  safe_q, safe_d;
	logic                  found_q, found_d;
	logic [CELL_W-1:0]     k_q, k_d;

	logic [COORD_W-1:0]    cx, cy;
	logic                  nb_ok;
	logic [CELL_W-1:0]     nb_cell;
	logic [DEPTH_W-1:0]    depth_dec;
	logic                  wr_en, rd_en;
	logic [CELL_W-1:0]     rd_addr;
	stack_entry_t          wr_entry, rd_entry;
	logic [ENTRY_W-1:0]    rd_raw;

	assign cx        = cur_q[CELL_W-1:COORD_W];
	assign cy        = cur_q[COORD_W-1:0];
	assign depth_dec = depth_q - DEPTH_W'(1);
	assign rd_entry  = stack_entry_t'(rd_raw);

	// neighbor in the direction under test
	always_comb begin
		nb_ok   = 1'b0;
		nb_cell = cur_q;
		case (dir_q)
			DIR_YDEC: begin
				nb_ok   = (cy != '0);
				nb_cell = {cx, cy - COORD_W'(1)};
			end
			DIR_XINC: begin
				nb_ok   = (cx != COORD_MAX);
				nb_cell = {cx + COORD_W'(1), cy};
			end
			DIR_XDEC: begin
				nb_ok   = (cx != '0);
				nb_cell = {cx - COORD_W'(1), cy};
			end
			DIR_YINC: begin
				nb_ok   = (cy != COORD_MAX);
				nb_cell = {cx, cy + COORD_W'(1)};
			end
			default: begin
				nb_ok   = 1'b0;
				nb_cell = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			depth_q  <= '0;
			onpath_q <= '0;
			found_q  <= 1'b0;
			k_q      <= '0;
		end else begin
			state_q  <= state_d;
			depth_q  <= depth_d;
			onpath_q <= onpath_d;
			found_q  <= found_d;
			k_q      <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		dir_q    <= dir_d;
		target_q <= target_d;
		safe_q   <= safe_d;
	end

	always_comb begin
		state_d  = state_q;
		depth_d  = depth_q;
		onpath_d = onpath_q;
		cur_d    = cur_q;
		dir_d    = dir_q;
		target_d = target_q;
		safe_d   = safe_q;
		found_d  = found_q;
		k_d      = k_q;
		in_ready = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = k_q;
		wr_entry = '{next_dir: dir_q + DIR_W'(1), pos: nb_cell, parent: cur_q};
		res_valid = 1'b0;
		res      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					depth_d  = '0;
					onpath_d = '0;
					cur_d    = start_cell;
					dir_d    = DIR_YDEC;
					target_d = target_cell;
					safe_d   = safe_map;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cur_q == target_q) begin
					found_d = 1'b1;
					k_d     = '0;
					state_d = (depth_q == '0) ? ST_RESULT : ST_EMIT_RD;
				end else if (depth_q == DEPTH_FULL) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_EXPLORE;
				end
			end
			ST_EXPLORE: begin
				if (dir_q == DIR_DONE) begin
					state_d = ST_POP;
				end else if (nb_ok && safe_q[nb_cell] && !onpath_q[nb_cell]) begin
					wr_en             = 1'b1;
					onpath_d[nb_cell] = 1'b1;
					depth_d           = depth_q + DEPTH_W'(1);
					cur_d             = nb_cell;
					dir_d             = DIR_YDEC;
					state_d           = ST_CHECK;
				end else begin
					dir_d = dir_q + DIR_W'(1);
				end
			end
			ST_POP: begin
				rd_addr = depth_dec[CELL_W-1:0];
				if (depth_q == '0) begin
					found_d = 1'b0;
					state_d = ST_RESULT;
				end else begin
					rd_en           = 1'b1;
					depth_d         = depth_dec;
					onpath_d[cur_q] = 1'b0;
					state_d         = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				cur_d   = rd_entry.parent;
				dir_d   = rd_entry.next_dir;
				state_d = ST_EXPLORE;
			end
			ST_EMIT_RD: begin
				rd_en   = 1'b1;
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				res_valid    = 1'b1;
				res.step_x   = rd_entry.pos[CELL_W-1:COORD_W];
				res.step_y   = rd_entry.pos[COORD_W-1:0];
				res.has_step = 1'b1;
				res.found    = 1'b1;
				res.last     = ({1'b0, k_q} == depth_dec);
				if (res_ready) begin
					if (res.last) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + CELL_W'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_RESULT: begin
				res_valid = 1'b1;
				res.found = found_q;
				res.last  = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	gdfs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_CELLS)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (depth_q[CELL_W-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

endmodule

// File: design/grid_dfs_path_finder.sv
// ----------------------------------------------------------------------------
// grid_dfs_path_finder
// depth-first path search on a 4x4 safe-cell grid, emits the path cell by cell
// ----------------------------------------------------------------------------
// flow: check the cell, then try neighbors in order until one is taken or all
// are tried; backtrack by pop and stack read; read each path beat from the ram
// into the output stage; start equal to target gives a single result beat
// throughput: one search at a time, next beat in once the final result sits in
// the output stage; search cycles depend on the map walked through the stack ram
// reset: arst_n clears the sequencer, path depth, on-path map and output stage
module grid_dfs_path_finder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// start_x, start_y, target_x, target_y, safe_map
	input  logic [gdfs_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// step_x, step_y, zero fill
	output logic [gdfs_pkg::OUT_W-1:0]   m_axis_tdata,
	// has_step, found
	output logic [gdfs_pkg::USER_W-1:0]  m_axis_tuser,
	output logic                         m_axis_tlast
);
	import gdfs_pkg::*;

	logic     res_valid, res_ready;
	result_t  res;
	logic     out_valid_q;
	result_t  out_q;

	gdfs_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.start_cell  ({s_axis_tdata[1:0], s_axis_tdata[3:2]}),
		.target_cell ({s_axis_tdata[5:4], s_axis_tdata[7:6]}),
		.safe_map    (s_axis_tdata[23:8]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - 2 * COORD_W){1'b0}}, out_q.step_y, out_q.step_x};
	assign m_axis_tuser  = {out_q.found, out_q.has_step};
	assign m_axis_tlast  = out_q.last;

endmodule

// File: design/gdfs_checker.sv
// ----------------------------------------------------------------------------
// gdfs_checker
// port-level checks of the path finder, bound to the top level
// ----------------------------------------------------------------------------
module gdfs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [gdfs_pkg::OUT_W-1:0]   m_axis_tdata,
	input logic [gdfs_pkg::USER_W-1:0]  m_axis_tuser,
	input logic                         m_axis_tlast
);
	import gdfs_pkg::*;

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// one search at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while search running");

	// empty result is a single final beat with zero cell
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("empty result not final or not zero");

	// path beats only on success
	a_step_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("path beat without found");

endmodule

bind grid_dfs_path_finder gdfs_checker u_gdfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// regression for grid_dfs_path_finder: directed requests (corner cells, each
// neighbor direction, start equal to target, walled-off and unsafe targets,
// dead ends, re-entry of the start cell) then random requests with random
// stalls on both streams; typed directed rows are checked against stored beats,
// all other path beats against a depth-first path predictor kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
	import gdfs_pkg::*;

	typedef struct packed {
		logic [COORD_W-1:0]   start_x;
		logic [COORD_W-1:0]   start_y;
		logic [COORD_W-1:0]   target_x;
		logic [COORD_W-1:0]   target_y;
		logic [NUM_CELLS-1:0] safe_map;
	} search_req_t;

	typedef struct {
		search_req_t req;
		bit          typed;
		result_t     beat;
	} directed_row_t;

	localparam int NUM_DIRECTED = 20;
	localparam int NUM_RANDOM   = 340;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic [USER_W-1:0]  m_axis_tuser;
	logic               m_axis_tlast;

	result_t path_beats_due [$];
	int      mismatches = 0;
	bit      calm = 1'b0;

	directed_row_t plan [NUM_DIRECTED] = '{
		'{'{2'd0, 2'd0, 2'd0, 2'd0, 16'h0000}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b1, 1'b1}},
		'{'{2'd3, 2'd3, 2'd3, 2'd3, 16'hFFFF}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b1, 1'b1}},
		'{'{2'd0, 2'd0, 2'd3, 2'd3, 16'h0000}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b0, 1'b1}},
		'{'{2'd1, 2'd1, 2'd2, 2'd2, 16'h0070}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b0, 1'b1}},
		'{'{2'd0, 2'd1, 2'd0, 2'd0, 16'h0001}, 1'b1, '{2'd0, 2'd0, 1'b1, 1'b1, 1'b1}},
		'{'{2'd0, 2'd0, 2'd1, 2'd0, 16'h0010}, 1'b1, '{2'd1, 2'd0, 1'b1, 1'b1, 1'b1}},
		'{'{2'd3, 2'd3, 2'd2, 2'd3, 16'h0800}, 1'b1, '{2'd2, 2'd3, 1'b1, 1'b1, 1'b1}},
		'{'{2'd2, 2'd2, 2'd2, 2'd3, 16'h0800}, 1'b1, '{2'd2, 2'd3, 1'b1, 1'b1, 1'b1}},
		'{'{2'd1, 2'd1, 2'd1, 2'd3, 16'h00C0}, 1'b0, '0},
		'{'{2'd0, 2'd1, 2'd0, 2'd2, 16'h0007}, 1'b0, '0},
		'{'{2'd0, 2'd0, 2'd3, 2'd3, 16'hFFFF}, 1'b0, '0},
		'{'{2'd3, 2'd0, 2'd0, 2'd3, 16'hFFFF}, 1'b0, '0},
		'{'{2'd0, 2'd0, 2'd0, 2'd3, 16'hFFFF}, 1'b0, '0},
		'{'{2'd0, 2'd0, 2'd3, 2'd3, 16'h8033}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b0, 1'b1}},
		'{'{2'd1, 2'd0, 2'd2, 2'd3, 16'hAAAA}, 1'b0, '0},
		'{'{2'd0, 2'd1, 2'd3, 2'd2, 16'h5555}, 1'b0, '0},
		'{'{2'd0, 2'd0, 2'd0, 2'd3, 16'h011F}, 1'b0, '0},
		'{'{2'd3, 2'd3, 2'd0, 2'd0, 16'hFFFF}, 1'b0, '0},
		'{'{2'd2, 2'd1, 2'd1, 2'd2, 16'hFFFF}, 1'b0, '0},
		'{'{2'd1, 2'd2, 2'd1, 2'd2, 16'hFFFF}, 1'b1, '{2'd0, 2'd0, 1'b0, 1'b1, 1'b1}}
	};

	grid_dfs_path_finder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// depth-first walk, queues the path beats of one request
	function automatic void predict_path(input search_req_t r);
		logic [CELL_W-1:0]    trail [NUM_CELLS];
		int                   next_try [NUM_CELLS+1];
		logic [NUM_CELLS-1:0] on_trail;
		int                   depth, cx, cy, nx, ny, d, idx;
		bit                   hit, moved;
		result_t              beat;
		depth = 0;
		on_trail = '0;
		next_try[0] = int'(DIR_YDEC);
		hit = 1'b0;
		while (1) begin
			if (depth == 0) begin
				cx = int'(r.start_x);
				cy = int'(r.start_y);
			end else begin
				cx = int'(trail[depth-1][CELL_W-1:COORD_W]);
				cy = int'(trail[depth-1][COORD_W-1:0]);
			end
			if (cx == r.target_x && cy == r.target_y) begin
				hit = 1'b1;
				break;
			end
			moved = 1'b0;
			if (depth < NUM_CELLS) begin
				for (d = next_try[depth]; d < DIR_DONE; d++) begin
					nx = cx;
					ny = cy;
					case (d)
						DIR_YDEC: ny = cy - 1;
						DIR_XINC: nx = cx + 1;
						DIR_XDEC: nx = cx - 1;
						default:  ny = cy + 1;
					endcase
					if (nx < 0 || nx >= GRID_SIDE || ny < 0 || ny >= GRID_SIDE) continue;
					idx = nx * GRID_SIDE + ny;
					if (!r.safe_map[idx] || on_trail[idx]) continue;
					next_try[depth] = d + 1;
					trail[depth] = CELL_W'(idx);
					on_trail[idx] = 1'b1;
					depth++;
					next_try[depth] = int'(DIR_YDEC);
					moved = 1'b1;
					break;
				end
			end
			if (moved) continue;
			if (depth == 0) break;
			depth--;
			on_trail[trail[depth]] = 1'b0;
		end
		if (!hit || depth == 0) begin
			beat = '{2'd0, 2'd0, 1'b0, hit, 1'b1};
			path_beats_due.push_back(beat);
		end else begin
			for (int k = 0; k < depth; k++) begin
				beat = '{trail[k][CELL_W-1:COORD_W], trail[k][COORD_W-1:0], 1'b1, 1'b1,
					k == depth - 1};
				path_beats_due.push_back(beat);
			end
		end
	endfunction

	task automatic offer_request(input search_req_t r, input bit typed, input result_t beat);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tdata  <= {r.safe_map, r.target_y, r.target_x, r.start_y, r.start_x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (typed) path_beats_due.push_back(beat);
		else predict_path(r);
	endtask

	// output stall pattern
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		result_t          due;
		logic [OUT_W-1:0] want_data;
		logic [USER_W-1:0] want_user;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (path_beats_due.size() == 0) begin
				$display("%0t unexpected beat: tdata %h tuser %b tlast %b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				mismatches++;
			end else begin
				due = path_beats_due.pop_front();
				want_data = {{(OUT_W - 2*COORD_W){1'b0}}, due.step_y, due.step_x};
				want_user = {due.found, due.has_step};
				if (m_axis_tdata !== want_data) begin
					$display("%0t tdata mismatch: expected %h actual %h", $time,
						want_data, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== want_user) begin
					$display("%0t tuser mismatch: expected %b actual %b", $time,
						want_user, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tlast !== due.last) begin
					$display("%0t tlast mismatch: expected %b actual %b", $time,
						due.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		search_req_t  r;
		logic [31:0]  a, b;
		result_t      none;
		none = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		foreach (plan[i]) offer_request(plan[i].req, plan[i].typed, plan[i].beat);
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM - 60) calm = 1'b1;
			a = $urandom;
			b = $urandom;
			r.start_x  = COORD_W'($urandom_range(0, 3));
			r.start_y  = COORD_W'($urandom_range(0, 3));
			r.target_x = COORD_W'($urandom_range(0, 3));
			r.target_y = COORD_W'($urandom_range(0, 3));
			case ($urandom_range(0, 2))
				0:       r.safe_map = a[15:0] & b[15:0];
				1:       r.safe_map = a[15:0];
				default: r.safe_map = a[15:0] | b[15:0];
			endcase
			// mostly a reachable-looking target
			if ($urandom_range(0, 4) < 3) r.safe_map[{r.target_x, r.target_y}] = 1'b1;
			offer_request(r, 1'b0, none);
		end
		s_axis_tvalid <= 1'b0;
		while (path_beats_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("grid_dfs_path_finder regression: pass");
		end else begin
			$display("grid_dfs_path_finder regression: fail");
		end
		$finish;
	end

	initial begin
		repeat (4) #1_000_000_000;
		$display("grid_dfs_path_finder regression: fail");
		$finish;
	end

endmodule
